### sv/assert_macros.svh
// Assertion macros used by budgeted_priority_evict_store.sv.
// Checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BPE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BPE_ASSERT(lbl, prop, msg)
`define BPE_NEVER(lbl, cond, msg)
`endif
`endif

### sv/bpe_pkg.sv
// Types and constants of the budgeted priority eviction store.
// No dependencies.
package bpe_pkg;
  localparam int MAX_ENTRIES  = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int AW           = $clog2(MAX_ENTRIES);
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
  localparam logic [15:0] BUDGET_RST = 16'd8192;
  localparam logic [19:0] BLEND_RECIP = 20'd838861;  // ceil(2^23 / 10)
  localparam int          BLEND_SHIFT = 23;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_BLEND = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_SHIFT,
    ST_WRITE,
    ST_BL_RD,
    ST_BL_WAIT,
    ST_BL_WR,
    ST_RD,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] entry_tag;
    logic [15:0] entry_size;
    logic [15:0] entry_weight;
    logic [15:0] blend_weight;
    logic [4:0]  slot_pos;
  } req_t;

  typedef struct packed {
    logic [15:0] out_tag;
    logic [15:0] out_size;
    logic [15:0] out_weight;
    logic        last_item;
    logic [15:0] total_size;
    logic [5:0]  entries_used;
    logic        full_flag;
    logic [5:0]  evicted_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] size;
    logic [15:0] weight;
  } entry_t;
endpackage

### sv/bpe_blend.sv
// Importance blend: floor((9*old + w) / 10); 9*old + w is registered, the reciprocal multiply is combinational.
// Depends on bpe_pkg.
module bpe_blend (
  input  logic        clk_i,
  input  logic [15:0] old_i,
  input  logic [15:0] weight_i,
  output logic [15:0] quot_o
);
  import bpe_pkg::*;

  logic [19:0] x_d, x_q;
  logic [39:0] prod;

  assign x_d = {1'b0, old_i, 3'b000} + {4'b0000, old_i} + {4'b0000, weight_i};

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  assign prod   = {20'd0, x_q} * {20'd0, BLEND_RECIP};
  assign quot_o = prod[BLEND_SHIFT+15:BLEND_SHIFT];
endmodule

### sv/budgeted_priority_evict_store.sv
// Top level of the budgeted priority eviction store: control and entry memory.
// Depends on bpe_pkg, bpe_blend and assert_macros.svh.
//
//  channel   signals                               direction
//  request   start, busy, req_i                    in  (accepted on start & !busy)
//  result    rsp_valid_o, rsp_o                    out (one-cycle strobe)
//  config    cfg_valid_i, cfg_ready_o, cfg_data_i  in  (size budget)
//
// Each eviction passes the evaluate state, scans the stored entries for the lowest weight,
// then shifts the younger entries down over it, all through one read port.
// Push: the evictions, then the write. Blend: read, blend and write back the slot if in use.
// Readout: one result per cycle. Reset clears count and sum, loads the budget.
// Results cannot be stalled; busy falls in the same cycle as the final result is out.
`include "assert_macros.svh"
module budgeted_priority_evict_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bpe_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output bpe_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i
);
  import bpe_pkg::*;

  state_e             state_q, state_d;
  req_t               req_q, req_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [15:0]        sum_q, sum_d;
  logic [15:0]        budget_q, budget_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               pend_q, pend_d;
  logic [CNT_W-1:0]   pend_idx_q, pend_idx_d;
  logic [CNT_W-1:0]   best_idx_q, best_idx_d;
  logic [15:0]        best_w_q, best_w_d;
  logic [15:0]        best_size_q, best_size_d;
  logic [5:0]         evict_q, evict_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;
  entry_t             hold_q, hold_d;

  entry_t             mem [MAX_ENTRIES];
  entry_t             rdata_q;
  logic [AW-1:0]      raddr, waddr;
  logic               we;
  entry_t             wdata;

  logic               accept;
  logic               over;
  logic [CNT_W-1:0]   n_rd;
  logic [15:0]        blend_q;
  logic               slot_ok;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign over    = ({1'b0, sum_q} + {1'b0, req_q.entry_size}) > {1'b0, budget_q};
  assign n_rd    = (cnt_q < CNT_W'(RESULT_LIMIT)) ? cnt_q : CNT_W'(RESULT_LIMIT);
  assign slot_ok = CNT_W'(req_q.slot_pos) < cnt_q;

  bpe_blend u_blend (
    .clk_i    (clk_i),
    .old_i    (rdata_q.weight),
    .weight_i (req_q.blend_weight),
    .quot_o   (blend_q)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_e'(req_i.req_type))
            REQ_PUSH:  state_d = ST_EVAL;
            REQ_BLEND: state_d = ST_BL_RD;
            REQ_READ:  state_d = (cnt_q == '0) ? ST_RESP : ST_RD;
            REQ_NOP:   state_d = ST_RESP;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_EVAL: begin
        if (cnt_q != '0 && (over || cnt_q >= CNT_W'(MAX_ENTRIES))) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_SCAN:    if (idx_q == cnt_q && !pend_q) state_d = ST_SHIFT;
      ST_SHIFT:   if (idx_q >= cnt_q && !pend_q) state_d = ST_EVAL;
      ST_WRITE:   state_d = ST_RESP;
      ST_BL_RD:   state_d = slot_ok ? ST_BL_WAIT : ST_RESP;
      ST_BL_WAIT: state_d = ST_BL_WR;
      ST_BL_WR:   state_d = ST_RESP;
      ST_RD:      if (pend_q && pend_idx_q == n_rd - 1'b1) state_d = ST_IDLE;
      ST_RESP:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_d       = req_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    budget_d    = budget_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    best_idx_d  = best_idx_q;
    best_w_d    = best_w_q;
    best_size_d = best_size_q;
    evict_d     = evict_q;
    hold_d      = hold_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    raddr       = idx_q[AW-1:0];
    waddr       = pend_idx_q[AW-1:0];
    we          = 1'b0;
    wdata       = rdata_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          budget_d = cfg_data_i;
        end
        if (accept) begin
          req_d   = req_i;
          evict_d = '0;
          idx_d   = '0;
          pend_d  = 1'b0;
        end
      end
      ST_EVAL: begin
        idx_d  = '0;
        pend_d = 1'b0;
      end
      ST_SCAN: begin
        if (idx_q < cnt_q) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          idx_d      = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && (pend_idx_q == '0 || rdata_q.weight < best_w_q)) begin
          best_idx_d  = pend_idx_q;
          best_w_d    = rdata_q.weight;
          best_size_d = rdata_q.size;
        end
        if (idx_q == cnt_q && !pend_q) begin
          idx_d = best_idx_q + 1'b1;
        end
      end
      ST_SHIFT: begin
        if (idx_q < cnt_q) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q - 1'b1;
          idx_d      = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          we = 1'b1;
        end
        if (idx_q >= cnt_q && !pend_q) begin
          cnt_d   = cnt_q - 1'b1;
          sum_d   = sum_q - best_size_q;
          evict_d = evict_q + 1'b1;
        end
      end
      ST_WRITE: begin
        we    = 1'b1;
        waddr = cnt_q[AW-1:0];
        wdata = '{tag: req_q.entry_tag, size: req_q.entry_size,
                  weight: req_q.entry_weight};
        cnt_d = cnt_q + 1'b1;
        sum_d = sum_q + req_q.entry_size;
      end
      ST_BL_RD: begin
        raddr = req_q.slot_pos[AW-1:0];
      end
      ST_BL_WAIT: begin
        raddr  = req_q.slot_pos[AW-1:0];
        hold_d = rdata_q;
      end
      ST_BL_WR: begin
        we    = 1'b1;
        waddr = req_q.slot_pos[AW-1:0];
        wdata = '{tag: hold_q.tag, size: hold_q.size, weight: blend_q};
      end
      ST_RD: begin
        if (idx_q < n_rd) begin
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          idx_d      = idx_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          rsp_valid_d         = 1'b1;
          rsp_d.out_tag       = rdata_q.tag;
          rsp_d.out_size      = rdata_q.size;
          rsp_d.out_weight    = rdata_q.weight;
          rsp_d.last_item     = (pend_idx_q == n_rd - 1'b1);
          rsp_d.total_size    = sum_q;
          rsp_d.entries_used  = 6'(cnt_q);
          rsp_d.full_flag     = (sum_q >= budget_q);
          rsp_d.evicted_count = '0;
        end
      end
      ST_RESP: begin
        rsp_valid_d         = 1'b1;
        rsp_d.out_tag       = '0;
        rsp_d.out_size      = '0;
        rsp_d.out_weight    = '0;
        rsp_d.last_item     = 1'b1;
        rsp_d.total_size    = sum_q;
        rsp_d.entries_used  = 6'(cnt_q);
        rsp_d.full_flag     = (sum_q >= budget_q);
        rsp_d.evicted_count = evict_q;
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sum_q       <= '0;
      budget_q    <= BUDGET_RST;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      evict_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      budget_q    <= budget_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
      evict_q     <= evict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    idx_q       <= idx_d;
    pend_idx_q  <= pend_idx_d;
    best_idx_q  <= best_idx_d;
    best_w_q    <= best_w_d;
    best_size_q <= best_size_d;
    hold_q      <= hold_d;
    rsp_q       <= rsp_d;
  end

  `BPE_NEVER(a_cnt_max, cnt_q > CNT_W'(MAX_ENTRIES), "entry count above capacity")
  `BPE_ASSERT(a_rsp_idle, rsp_valid_o |-> !busy || state_q == ST_RD, "result while busy")
  `BPE_ASSERT(a_accept_busy, accept |=> busy, "accepted request did not raise busy")
  `BPE_ASSERT(a_shift_range, (state_q == ST_SHIFT && pend_q) |-> pend_idx_q < cnt_q, "bad shift")
endmodule

### sim/budgeted_priority_evict_store_tb.sv
// Testbench for budgeted_priority_evict_store: drives push, blend, readout and
// no-op requests, predicts every result and compares each one field by field.
// Depends on bpe_pkg and the RTL of the store.
`timescale 1ns / 1ps
module budgeted_priority_evict_store_tb;
  import bpe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  req_t  req_i = '0;
  logic  rsp_valid_o;
  rsp_t  rsp_o;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  logic  [15:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  budgeted_priority_evict_store u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .rsp_valid_o, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // predicted store contents
  logic [15:0] mdl_tag [MAX_ENTRIES];
  logic [15:0] mdl_size [MAX_ENTRIES];
  logic [15:0] mdl_weight [MAX_ENTRIES];
  int unsigned mdl_count;
  int unsigned mdl_sum;
  int unsigned mdl_budget;

  req_t request_queue[$];
  rsp_t expected_rsp[$];
  int   errors = 0;
  int   cycles = 0;
  int   gap = 0;
  bit   hold_requests = 1'b0;

  function automatic void queue_req(req_t rq);
    request_queue = {request_queue, rq};
  endfunction

  function automatic void expect_rsp(rsp_t r);
    expected_rsp = {expected_rsp, r};
  endfunction

  function automatic rsp_t status_rsp(logic [15:0] tag, logic [15:0] size,
                                      logic [15:0] weight, bit last, int unsigned ev);
    rsp_t r;
    r.out_tag = tag;
    r.out_size = size;
    r.out_weight = weight;
    r.last_item = last;
    r.total_size = mdl_sum[15:0];
    r.entries_used = mdl_count[5:0];
    r.full_flag = mdl_sum >= mdl_budget;
    r.evicted_count = ev[5:0];
    return r;
  endfunction

  task automatic evict_least_important();
    int unsigned low;
    low = 0;
    if (mdl_count == 0) return;
    for (int unsigned i = 1; i < mdl_count; i++)
      if (mdl_weight[i] < mdl_weight[low]) low = i;
    mdl_sum -= mdl_size[low];
    for (int unsigned i = low; i + 1 < mdl_count; i++) begin
      mdl_tag[i] = mdl_tag[i+1];
      mdl_size[i] = mdl_size[i+1];
      mdl_weight[i] = mdl_weight[i+1];
    end
    mdl_count--;
  endtask

  task automatic predict_store(req_t rq);
    int unsigned ev;
    int unsigned n;
    ev = 0;
    case (req_type_e'(rq.req_type))
      REQ_PUSH: begin
        while (mdl_count > 0 && mdl_sum + rq.entry_size > mdl_budget) begin
          evict_least_important();
          ev++;
        end
        if (mdl_count >= MAX_ENTRIES) begin
          evict_least_important();
          ev++;
        end
        mdl_tag[mdl_count] = rq.entry_tag;
        mdl_size[mdl_count] = rq.entry_size;
        mdl_weight[mdl_count] = rq.entry_weight;
        mdl_count++;
        mdl_sum += rq.entry_size;
        expect_rsp(status_rsp(0, 0, 0, 1, ev));
      end
      REQ_BLEND: begin
        if (rq.slot_pos < mdl_count)
          mdl_weight[rq.slot_pos] = 16'((9 * int'(mdl_weight[rq.slot_pos])
                                         + int'(rq.blend_weight)) / 10);
        expect_rsp(status_rsp(0, 0, 0, 1, 0));
      end
      REQ_READ: begin
        n = mdl_count < RESULT_LIMIT ? mdl_count : RESULT_LIMIT;
        if (n == 0) expect_rsp(status_rsp(0, 0, 0, 1, 0));
        for (int unsigned i = 0; i < n; i++)
          expect_rsp(status_rsp(mdl_tag[i], mdl_size[i], mdl_weight[i],
                                i + 1 == n, 0));
      end
      default: expect_rsp(status_rsp(0, 0, 0, 1, 0));
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_store(req_i);
        gap <= $urandom_range(0, 10);
      end
      if (start && !busy) begin
        if (request_queue.size() > 0 && !hold_requests && $urandom_range(0, 10) == 0
            && $urandom_range(0, 1) == 0) begin
          start <= 1'b0;
        end else if (request_queue.size() > 0 && !hold_requests
                     && $urandom_range(0, 10) == 0) begin
          req_i <= request_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (gap > 0) gap <= gap - 1;
        else if (request_queue.size() > 0 && !hold_requests) begin
          req_i <= request_queue.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t exp_r;
    cycles <= cycles + 1;
    if (rst_ni && rsp_valid_o) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        exp_r = expected_rsp.pop_front();
        if (rsp_o.out_tag !== exp_r.out_tag) begin
          $error("out_tag exp %0d got %0d", exp_r.out_tag, rsp_o.out_tag);
          errors++;
        end
        if (rsp_o.out_size !== exp_r.out_size) begin
          $error("out_size exp %0d got %0d", exp_r.out_size, rsp_o.out_size);
          errors++;
        end
        if (rsp_o.out_weight !== exp_r.out_weight) begin
          $error("out_weight exp %0d got %0d", exp_r.out_weight, rsp_o.out_weight);
          errors++;
        end
        if (rsp_o.last_item !== exp_r.last_item) begin
          $error("last_item exp %0d got %0d", exp_r.last_item, rsp_o.last_item);
          errors++;
        end
        if (rsp_o.total_size !== exp_r.total_size) begin
          $error("total_size exp %0d got %0d", exp_r.total_size, rsp_o.total_size);
          errors++;
        end
        if (rsp_o.entries_used !== exp_r.entries_used) begin
          $error("entries_used exp %0d got %0d", exp_r.entries_used, rsp_o.entries_used);
          errors++;
        end
        if (rsp_o.full_flag !== exp_r.full_flag) begin
          $error("full_flag exp %0d got %0d", exp_r.full_flag, rsp_o.full_flag);
          errors++;
        end
        if (rsp_o.evicted_count !== exp_r.evicted_count) begin
          $error("evicted_count exp %0d got %0d", exp_r.evicted_count,
                 rsp_o.evicted_count);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic req_t make_req(req_type_e op, logic [15:0] tag, logic [15:0] size,
                                    logic [15:0] weight, logic [15:0] bw, logic [4:0] pos);
    req_t rq;
    rq.req_type = op;
    rq.entry_tag = tag;
    rq.entry_size = size;
    rq.entry_weight = weight;
    rq.blend_weight = bw;
    rq.slot_pos = pos;
    return rq;
  endfunction

  function automatic req_t random_req(int unsigned budget);
    int unsigned pick;
    logic [15:0] sz;
    pick = $urandom_range(0, 99);
    sz = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, budget / 6 + 1));
    if (pick < 55)
      return make_req(REQ_PUSH, 16'($urandom), sz, 16'($urandom), 16'($urandom),
                      5'($urandom));
    if (pick < 80)
      return make_req(REQ_BLEND, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 5'($urandom));
    if (pick < 93)
      return make_req(REQ_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 5'($urandom));
    return make_req(REQ_NOP, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 5'($urandom));
  endfunction

  task automatic wait_drained();
    while (request_queue.size() > 0 || start || busy || expected_rsp.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_budget(logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mdl_budget = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] budgets [5];
    budgets = '{16'd8192, 16'd65535, 16'd1, 16'd300, 16'd0};
    mdl_count = 0;
    mdl_sum = 0;
    mdl_budget = BUDGET_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty readout, extremes, blend past count, oversized push
    queue_req(make_req(REQ_READ, 0, 0, 0, 0, 0));
    queue_req(make_req(REQ_BLEND, 0, 0, 0, 16'hFFFF, 0));
    queue_req(make_req(REQ_PUSH, 16'hFFFF, 16'd100, 16'd4096, 0, 0));
    queue_req(make_req(REQ_PUSH, 16'h0000, 16'd0, 16'hFFFF, 0, 0));
    queue_req(make_req(REQ_PUSH, 16'h1234, 16'd200, 16'd0, 0, 0));
    queue_req(make_req(REQ_PUSH, 16'h5678, 16'd50, 16'd0, 0, 0));
    queue_req(make_req(REQ_BLEND, 0, 0, 0, 16'hFFFF, 5'd1));
    queue_req(make_req(REQ_BLEND, 0, 0, 0, 16'd0, 5'd0));
    queue_req(make_req(REQ_BLEND, 0, 0, 0, 16'd7, 5'd31));
    queue_req(make_req(REQ_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31));
    queue_req(make_req(REQ_READ, 0, 0, 0, 0, 0));
    queue_req(make_req(REQ_PUSH, 16'hABCD, 16'hFFFF, 16'd4096, 0, 0));
    queue_req(make_req(REQ_READ, 0, 0, 0, 0, 0));
    queue_req(make_req(REQ_PUSH, 16'h0001, 16'd8192, 16'd1, 0, 0));
    queue_req(make_req(REQ_READ, 0, 0, 0, 0, 0));
    wait_drained();

    // full slots: 34 small pushes then a readout
    for (int i = 0; i < 34; i++)
      queue_req(make_req(REQ_PUSH, 16'($urandom), 16'($urandom_range(0, 3)),
                         16'($urandom_range(0, 7)), 0, 0));
    queue_req(make_req(REQ_READ, 0, 0, 0, 0, 0));
    wait_drained();

    foreach (budgets[b]) begin
      write_budget(budgets[b]);
      for (int i = 0; i < 21; i++)
        queue_req(random_req(budgets[b]));
      queue_req(make_req(REQ_READ, 0, 0, 0, 0, 0));
      if (b == 1) begin
        while (request_queue.size() > 10) @(posedge clk_i);
        hold_requests = 1'b1;
        while (start || busy || expected_rsp.size() > 0) @(posedge clk_i);
        hold_requests = 1'b0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### files.f
+incdir+sv
sv/bpe_pkg.sv
sv/bpe_blend.sv
sv/budgeted_priority_evict_store.sv
sim/budgeted_priority_evict_store_tb.sv
